// ===== hw/rtl/spr_pkg.sv =====
// shared types, constants and register codes of the stream pattern replacer
package spr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPL        = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int RUN_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int RUN_IDX_W       = $clog2(MAX_RESULTS);
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 64;
    localparam int LEN_W           = 4;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } spr_reg_idx_t;

    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } spr_cfg_t;

    // result list caused by one input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]        count;
        logic                        has_byte;
        logic                        done;
    } spr_run_t;

endpackage

// ===== hw/rtl/spr_cfg_regs.sv =====
// apb configuration registers: pattern, replacement and their lengths
module spr_cfg_regs
    import spr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output spr_cfg_t              cfg
);

    logic [63:0]      pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [63:0]      replacement_bytes_reg;
    logic [LEN_W-1:0] replacement_length_reg;
    logic             wr_en;
    spr_reg_idx_t     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = spr_reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= pwdata[63:0];
                REG_PATTERN_LENGTH:     pattern_length_reg     <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= pwdata[63:0];
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= pwdata[LEN_W-1:0];
                default:                pattern_bytes_reg      <= pattern_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_BYTES:      prdata = APB_DATA_W'(pattern_bytes_reg);
            REG_PATTERN_LENGTH:     prdata = APB_DATA_W'(pattern_length_reg);
            REG_REPLACEMENT_BYTES:  prdata = APB_DATA_W'(replacement_bytes_reg);
            REG_REPLACEMENT_LENGTH: prdata = APB_DATA_W'(replacement_length_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.pattern_bytes      = pattern_bytes_reg;
    assign cfg.pattern_length     = pattern_length_reg;
    assign cfg.replacement_bytes  = replacement_bytes_reg;
    assign cfg.replacement_length = replacement_length_reg;

endmodule

// ===== hw/rtl/spr_window.sv =====
// sliding window, pattern compare and result list for one input byte
module spr_window
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  spr_cfg_t   cfg,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output spr_run_t   run,
    output logic       run_load
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0][7:0] window_reg;
    logic [MAX_PATTERN-1:0][7:0] window_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;

    logic [MAX_PATTERN-1:0][7:0] w;
    logic [FILL_W-1:0]           fill0;
    logic [FILL_W-1:0]           fill1;
    logic [FILL_W-1:0]           plen;
    logic [RUN_CNT_W-1:0]        rlen;
    logic [FILL_W-1:0]           drain;
    logic                        eq;
    logic                        match;
    spr_run_t                    res;

    always_comb
    begin
        fill0 = (fill_reg >= FILL_MAX) ? FILL_MAX - 1'b1 : fill_reg;
        fill1 = fill0 + 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            w[i] = (FILL_W'(i) == fill0) ? data_byte : window_reg[i];
        end

        plen = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? FILL_MAX
             : cfg.pattern_length[FILL_W-1:0];
        rlen = (cfg.replacement_length > LEN_W'(MAX_REPL)) ? RUN_CNT_W'(MAX_REPL)
             : RUN_CNT_W'(cfg.replacement_length);

        eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((FILL_W'(i) < plen) && (w[i] != cfg.pattern_bytes[8*i +: 8]))
            begin
                eq = 1'b0;
            end
        end
        match = (plen != '0) && (fill1 == plen) && eq;

        // number of oldest window bytes that leave in this step
        if (plen == '0)
        begin
            drain = fill1;
        end
        else if (fill1 > plen)
        begin
            drain = fill1 - plen + 1'b1;
        end
        else if ((fill1 == plen) && !match)
        begin
            drain = FILL_W'(1);
        end
        else
        begin
            drain = '0;
        end
        if (stream_end && !match)
        begin
            drain = fill1;
        end

        fill_next = (match || stream_end) ? '0 : fill1 - drain;

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            window_next[i] = '0;
            for (int d = 0; d < MAX_PATTERN - i; d++)
            begin
                if (drain == FILL_W'(d))
                begin
                    window_next[i] = w[i + d];
                end
            end
        end

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res.bytes[k] = match ? cfg.replacement_bytes[8*k +: 8] : 8'd0;
        end
        if (!match)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                res.bytes[k] = w[k];
            end
        end
        res.count    = match ? rlen : RUN_CNT_W'(drain);
        res.has_byte = 1'b1;
        res.done     = stream_end;
        // bare end marker when the final byte leaves nothing to send
        if (stream_end && (res.count == '0))
        begin
            res.count    = RUN_CNT_W'(1);
            res.has_byte = 1'b0;
            res.bytes    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (step)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

    assign run      = res;
    assign run_load = step && (res.count != '0);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX - 1'b1)
        else $error("window fill exceeds pattern depth minus one");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && stream_end |=> fill_reg == '0)
        else $error("window not empty after stream end");

endmodule

// ===== hw/rtl/spr_out_seq.sv =====
// result list buffer and output register, one result per transfer
module spr_out_seq
    import spr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spr_run_t   run,
    input  logic       run_load,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       run_last,
    output logic       stream_done
);

    spr_run_t             run_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 busy_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 has_byte_reg;
    logic                 run_last_reg;
    logic                 stream_done_reg;

    logic                 load_out;
    logic                 last_entry;

    assign load_out   = busy_reg && (!out_valid_reg || out_ready);
    assign last_entry = (RUN_CNT_W'(idx_reg) + 1'b1) == run_reg.count;
    // a new list may enter once the last entry of the current one moves out
    assign free       = !busy_reg || (load_out && last_entry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (run_load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (load_out)
        begin
            if (last_entry)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_load)
        begin
            run_reg <= run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg    <= run_reg.bytes[idx_reg];
            has_byte_reg    <= run_reg.has_byte;
            run_last_reg    <= last_entry;
            stream_done_reg <= last_entry && run_reg.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign has_byte    = has_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;

    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (RUN_CNT_W'(idx_reg) < run_reg.count))
        else $error("result index past end of list");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        run_load |-> free)
        else $error("result list loaded while previous one pending");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stream_done_reg |-> run_last_reg)
        else $error("stream done on a result that is not last of its byte");

endmodule

// ===== hw/rtl/stream_pattern_replace_top.sv =====
// Streaming find-and-replace over a byte stream, top level.
//
// Input channel (in_valid/in_ready) carries one byte and a stream_end flag
// per transfer. Output channel (out_valid/out_ready) carries one result per
// transfer: out_byte, has_byte, run_last on the last result caused by an
// input byte, stream_done on the last result of a stream. A match of the
// configured pattern emits the replacement bytes; other bytes pass through
// once the window is full. A byte may cause zero to eight results.
// The results of a byte pass through the result list buffer and then the
// output register. Throughput: one result per cycle through the output
// register while the receiver takes them; a byte with several results
// holds the input until its last result moves out, since the result list
// buffer takes a new list only as its last entry leaves.
// Bytes that cause no result are taken one per cycle while in_ready is high.
// Configuration is an apb port with 64-bit registers at 8-byte steps. The
// user must write it only while the block is idle; the block does not
// enforce this. Reset clears the window, the registers and all valid flags;
// no clearing pass is needed. A stalled receiver holds the output register
// and, once the list buffer is full, drops in_ready.
module stream_pattern_replace_top
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  stream_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  has_byte,
    output logic                  run_last,
    output logic                  stream_done
);

    spr_cfg_t cfg;
    spr_run_t run;
    logic     run_load;
    logic     free;
    logic     step;

    assign in_ready = free;
    assign step     = in_valid && free;

    spr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (step),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .run        (run),
        .run_load   (run_load)
    );

    spr_out_seq u_out_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .run         (run),
        .run_load    (run_load),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

endmodule

// ===== bench/spr_checker.sv =====
// checker for the stream pattern replacer: tracks register writes, predicts and compares results
`timescale 1ns / 100ps

module spr_checker
    import spr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  stream_end,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            out_byte,
    input  logic                  has_byte,
    input  logic                  run_last,
    input  logic                  stream_done,
    output int                    errors,
    output int                    outstanding,
    output int                    results_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       filled;
        logic       last_of_run;
        logic       end_of_stream;
    } spr_result_t;

    // register copies
    logic [63:0]      pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic [63:0]      rep_bytes;
    logic [LEN_W-1:0] rep_len;

    // window of bytes not yet emitted
    logic [7:0]  win [MAX_PATTERN_DEF];
    int          fill;

    spr_result_t run_out[$];
    spr_result_t expected_q[$];

    function automatic void emit(input logic [7:0] data, input logic filled);
        run_out.push_back('{data: data, filled: filled, last_of_run: 1'b0,
                            end_of_stream: 1'b0});
    endfunction

    // emit the n oldest window bytes and shift the rest down
    function automatic void drain_oldest(input int n);
        int i;
        if (n > fill)
            n = fill;
        for (i = 0; i < n; i++)
            emit(win[i], 1'b1);
        for (i = 0; i + n < fill; i++)
            win[i] = win[i + n];
        fill -= n;
    endfunction

    function automatic void replace_step(input logic [7:0] b, input logic fin);
        int          plen;
        int          rlen;
        int          i;
        logic        hit;
        spr_result_t r;
        plen = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        rlen = (rep_len > MAX_REPL) ? MAX_REPL : int'(rep_len);
        run_out.delete();
        if (fill >= MAX_PATTERN_DEF)
            fill = MAX_PATTERN_DEF - 1;
        win[fill] = b;
        fill++;
        if (plen == 0)
            drain_oldest(fill);
        else if (fill > plen)
            drain_oldest(fill - plen + 1);
        else if (fill == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (win[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (i = 0; i < rlen; i++)
                    emit(rep_bytes[8*i +: 8], 1'b1);
                fill = 0;
            end
            else
                drain_oldest(1);
        end
        if (fin) begin
            drain_oldest(fill);
            fill = 0;
            // match with empty replacement on the final byte leaves a bare end marker
            if (run_out.size() == 0)
                emit(8'h00, 1'b0);
        end
        for (i = 0; i < run_out.size(); i++) begin
            r = run_out[i];
            if (i == run_out.size() - 1) begin
                r.last_of_run = 1'b1;
                r.end_of_stream = fin;
            end
            expected_q.push_back(r);
        end
    endfunction

    task automatic note_failure(input string what, input spr_result_t want,
                                input spr_result_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected byte %h has %b last %b done %b, got byte %h has %b last %b done %b",
                     $time, what, want.data, want.filled, want.last_of_run, want.end_of_stream,
                     got.data, got.filled, got.last_of_run, got.end_of_stream);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spr_result_t got;
        spr_result_t want;
        if (!rst_n) begin
            pat_bytes = '0;
            pat_len = '0;
            rep_bytes = '0;
            rep_len = '0;
            for (int i = 0; i < MAX_PATTERN_DEF; i++)
                win[i] = 8'h00;
            fill = 0;
            run_out.delete();
            expected_q.delete();
            errors = 0;
            outstanding = 0;
            results_checked = 0;
        end
        else begin
            // output transfer first: it always belongs to an older input byte
            if (out_valid && out_ready) begin
                got = '{data: out_byte, filled: has_byte, last_of_run: run_last,
                        end_of_stream: stream_done};
                results_checked++;
                if (expected_q.size() == 0)
                    note_failure("unexpected result", '0, got);
                else begin
                    want = expected_q.pop_front();
                    if (want != got)
                        note_failure("result mismatch", want, got);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (spr_reg_idx_t'(paddr[4:3]))
                    REG_PATTERN_BYTES:      pat_bytes = pwdata;
                    REG_PATTERN_LENGTH:     pat_len = pwdata[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES:  rep_bytes = pwdata;
                    REG_REPLACEMENT_LENGTH: rep_len = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                replace_step(data_byte, stream_end);
            outstanding = expected_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// testbench top for the stream pattern replacer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb
    import spr_pkg::*;
();

    localparam int LONG_HOLD  = 200;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte = 8'h00;
    logic                  stream_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  has_byte;
    logic                  run_last;
    logic                  stream_done;

    int   chk_errors;
    int   chk_outstanding;
    int   chk_results;

    int   bytes_sent = 0;
    int   streams_sent = 0;
    int   settings_used = 0;
    logic tx_calm = 1'b0;
    logic hold_go = 1'b0;
    int   quiet = 0;

    always #5 clk = ~clk;

    stream_pattern_replace_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

    spr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .stream_end      (stream_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .has_byte        (has_byte),
        .run_last        (run_last),
        .stream_done     (stream_done),
        .errors          (chk_errors),
        .outstanding     (chk_outstanding),
        .results_checked (chk_results)
    );

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        stream_end <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (fin)
            streams_sent++;
        @(negedge clk);
    endtask

    // sender stops until every expected result is out, plus settle time
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        wait (chk_outstanding == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // setup cycle then access cycle; psel is released by the caller
    task automatic reg_write(input spr_reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(int'(idx) * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] pat, input int plen,
                             input logic [63:0] rep, input int rlen);
        reg_write(REG_PATTERN_BYTES, pat);
        reg_write(REG_PATTERN_LENGTH, APB_DATA_W'(plen));
        reg_write(REG_REPLACEMENT_BYTES, rep);
        reg_write(REG_REPLACEMENT_LENGTH, APB_DATA_W'(rlen));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // receiver: random stalls, calm stretches, one long hold-off on request
    initial
    begin : receiver
        int   rx_wait;
        int   rx_cycle;
        logic rx_calm;
        logic hold_done;
        rx_wait = 0;
        rx_cycle = 0;
        rx_calm = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                rx_wait = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (rx_wait > 0) begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else begin
                out_ready <= 1'b1;
                rx_wait = pick_gap(rx_calm);
            end
            rx_cycle++;
            if (rx_cycle % 100 == 0)
                rx_calm = ($urandom_range(2) == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet <= 0;
        else if (quiet >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin : stimulus
        logic [63:0] pat;
        logic [63:0] rep;
        int          plen;
        int          rlen;
        int          ph;
        int          budget;
        int          len;
        int          k;
        int          pos;
        int          r;
        logic [7:0]  b;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pass-through straight after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        pause_until_drained();

        // two-byte pattern, leftmost match after a false start
        configure(64'h6261, 2, 64'h5A5958, 3);
        send_byte(8'h78, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h71, 1'b1);
        pause_until_drained();

        // full-length pattern, empty replacement matched on the final byte,
        // then a one-byte stream flushed from a partial window
        pat = 64'h80FF_7F01_00FE_55AA;
        configure(pat, 8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        for (k = 0; k < 8; k++)
            send_byte(pat[8*k +: 8], k == 7);
        send_byte(8'hAA, 1'b1);
        pause_until_drained();

        // one-byte pattern with the longest replacement
        configure(64'h0, 1, 64'hEFCD_AB89_6745_2301, 8);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);
        pause_until_drained();

        // pattern shortened, then emptied, while the window holds bytes
        configure(64'h1122_3344_5566, 6, 64'h7777, 2);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h40, 1'b0);
        pause_until_drained();
        configure(64'h1122_3344_5566, 2, 64'h7777, 2);
        send_byte(8'h50, 1'b0);
        pause_until_drained();
        configure(64'h1122_3344_5566, 0, 64'h7777, 2);
        send_byte(8'h60, 1'b1);
        pause_until_drained();

        // random streams built mostly from pattern fragments
        for (ph = 0; ph < 8; ph++) begin
            pat = {$urandom, $urandom};
            rep = {$urandom, $urandom};
            plen = $urandom_range(0, 8);
            rlen = $urandom_range(0, 8);
            case (ph)
                0: begin plen = 8; rlen = 8; end
                1: begin plen = 1; rlen = 0; end
                2: plen = 0;
                5: pat = '1;
                6: pat = '0;
                default: ;
            endcase
            configure(pat, plen, rep, rlen);
            // receiver stalls for long while the sender keeps offering
            if (ph == 3)
                hold_go <= 1'b1;
            budget = 18;
            while (budget > 0) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
                tx_calm = ($urandom_range(3) == 0);
                pos = 0;
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(99);
                    if (plen == 0 || r >= 85)
                        b = 8'($urandom_range(255));
                    else begin
                        if (r >= 70)
                            pos = 0;
                        b = pat[8*pos +: 8];
                        pos = (pos + 1) % plen;
                    end
                    send_byte(b, k == len - 1);
                end
                budget -= len;
                if (ph == 4 && budget > 0)
                    pause_until_drained();
            end
            pause_until_drained();
        end

        repeat (8) @(negedge clk);
        $display("covered %0d input bytes in %0d streams under %0d register settings",
                 bytes_sent, streams_sent, settings_used);
        $display("%0d results checked, %0d failures", chk_results, chk_errors);
        if (chk_errors == 0 && chk_outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== stream_pattern_replace_top.f =====
hw/rtl/spr_pkg.sv
hw/rtl/spr_cfg_regs.sv
hw/rtl/spr_window.sv
hw/rtl/spr_out_seq.sv
hw/rtl/stream_pattern_replace_top.sv
bench/spr_checker.sv
bench/tb.sv
